>>> hdl/rsd_pkg.sv
`default_nettype none

package rsd_pkg;

   // field widths of one record and of the result beat
   localparam int DIST_W     = 25;
   localparam int SPEED_W    = 9;
   localparam int LABEL_W    = 8;
   localparam int RANK_W     = 5;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   // request kinds carried on req_tuser
   typedef enum logic {
      FUNC_APPEND = 1'b0,
      FUNC_FLUSH  = 1'b1
   } func_type;

   // one stored record, distance in the low bits
   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [SPEED_W-1:0] speed_kmh;
      logic [DIST_W-1:0]  distance_m;
   } record_type;

   localparam int REC_W = $bits(record_type);

   // classified command handed from front end to sorter
   typedef struct packed {
      func_type   func;
      record_type rec;
   } cmd_type;

endpackage

`default_nettype wire

>>> hdl/record_sort_by_distance.sv
// Appends: one beat per cycle while the sorter is loading; a record goes into the
//   front-end queue, then the chain writes it into the sort row (stalled in drain).
// Flush of n records: beats leave the output register, one beat per cycle from the
//   drain shift while rsp_tready allows; an empty flush gives one marked beat.
// Reset (synchronous, active high) empties the queue, the row and the output
//   register; record contents are not cleared and need no clearing pass.
`default_nettype none

module record_sort_by_distance
   import rsd_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [24:0] distance_m, [33:25] speed_kmh, [41:34] label, [47:42] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] func
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [24:0] out_distance_m, [33:25] out_speed_kmh, [41:34] out_label,
   // [46:42] rank, [47] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   // [0] none
   output logic                       rsp_tuser
);

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   rsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready)
   );

   rsd_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_ready  (cmd_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> hdl/rsd_front.sv
`default_nettype none

module rsd_front
   import rsd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic                       cmd_valid,
   output cmd_type                    cmd,
   input  wire logic                  cmd_ready
);

   localparam int QUEUE_DEPTH = 2;

   cmd_type    queue_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    cmd_new;
   logic       push, pop;

   // classify the incoming beat
   always_comb begin
      cmd_new.func = func_type'(req_tuser);
      cmd_new.rec  = record_type'(req_tdata[REC_W-1:0]);
   end

   assign req_tready = (fill_ff != 2'(QUEUE_DEPTH));
   assign cmd_valid  = (fill_ff != 2'd0);
   assign cmd        = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

>>> hdl/rsd_back.sv
`default_nettype none

module rsd_back
   import rsd_pkg::*;
#(
   parameter int TABLE_DEPTH = 32
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  cmd_valid,
   input  wire cmd_type               cmd,
   output logic                       cmd_ready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [RANK_W-1:0]   rank_ff;
   logic                rsp_valid_ff;
   record_type          out_rec_ff;
   logic [RANK_W-1:0]   out_rank_ff;
   logic                out_last_ff;
   logic                out_none_ff;

   record_type          store_ff   [TABLE_DEPTH];
   record_type          store_in   [TABLE_DEPTH];
   record_type          prev_rec   [TABLE_DEPTH];
   record_type          next_rec   [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] gt;
   logic [TABLE_DEPTH-1:0] gt_up;

   logic out_free, full, take, do_insert, do_start, do_empty, do_emit;

   // handshake decode
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign cmd_ready = (state_ff == ST_LOAD)
                      && (cmd.func == FUNC_APPEND || count_ff != '0 || out_free);
   assign take      = cmd_valid && cmd_ready;
   assign do_insert = take && cmd.func == FUNC_APPEND && !full;
   assign do_start  = take && cmd.func == FUNC_FLUSH && count_ff != '0;
   assign do_empty  = take && cmd.func == FUNC_FLUSH && count_ff == '0;
   assign do_emit   = (state_ff == ST_DRAIN) && out_free;

   // insertion chain: each cell compares with the new key, shifts up or
   // takes the new record; on drain the whole row shifts down one place
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign gt[i] = (CNT_W'(i) < count_ff)
                     && (store_ff[i].distance_m > cmd.rec.distance_m);

      if (i == 0) begin : g_first
         assign prev_rec[i] = '0;
         assign gt_up[i]    = 1'b0;
      end else begin : g_rest
         assign prev_rec[i] = store_ff[i-1];
         assign gt_up[i]    = gt[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_top
         assign next_rec[i] = store_ff[i];
      end else begin : g_below
         assign next_rec[i] = store_ff[i+1];
      end

      always_comb begin
         store_in[i] = store_ff[i];
         if (do_emit) begin
            store_in[i] = next_rec[i];
         end else if (do_insert) begin
            if (gt_up[i]) begin
               store_in[i] = prev_rec[i];
            end else if (gt[i] || CNT_W'(i) == count_ff) begin
               store_in[i] = cmd.rec;
            end
         end
      end

      always_ff @(posedge clock) begin
         store_ff[i] <= store_in[i];
      end
   end

   // load / drain sequencer with output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register refills on an empty flush or a drain step
         if (out_free) begin
            rsp_valid_ff <= do_empty || do_emit;
         end
         case (state_ff)
            ST_LOAD: begin
               if (do_insert) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
               if (do_start) begin
                  state_ff <= ST_DRAIN;
                  rank_ff  <= '0;
               end
               if (do_empty) begin
                  out_rec_ff   <= '0;
                  out_rank_ff  <= '0;
                  out_last_ff  <= 1'b1;
                  out_none_ff  <= 1'b1;
               end
            end
            ST_DRAIN: begin
               if (out_free) begin
                  out_rec_ff   <= store_ff[0];
                  out_rank_ff  <= rank_ff;
                  out_last_ff  <= (count_ff == CNT_W'(1));
                  out_none_ff  <= 1'b0;
                  rank_ff      <= rank_ff + RANK_W'(1);
                  count_ff     <= count_ff - CNT_W'(1);
                  if (count_ff == CNT_W'(1)) begin
                     state_ff <= ST_LOAD;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, out_rank_ff, out_rec_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_none_ff;

endmodule

`default_nettype wire

>>> hdl/rsd_check.sv
`default_nettype none

module rsd_check
   import rsd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic                  rsp_tuser
);

   logic              in_frame_ff;
   logic [DIST_W-1:0] prev_dist_ff;
   logic [RANK_W-1:0] next_rank_ff;
   logic [DIST_W-1:0] rsp_dist;
   logic [RANK_W-1:0] rsp_rank;

   assign rsp_dist = rsp_tdata[DIST_W-1:0];
   assign rsp_rank = rsp_tdata[REC_W+RANK_W-1:REC_W];

   // track the beat before, within one flush
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         in_frame_ff  <= !rsp_tlast;
         prev_dist_ff <= rsp_dist;
         next_rank_ff <= rsp_rank + RANK_W'(1);
      end
   end

   // empty flush: single marked beat with cleared fields
   a_none_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == '0)
      else $error("empty-flush beat not last or not zero");

   // a flush starts at rank zero
   a_first_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !in_frame_ff |-> rsp_rank == '0)
      else $error("flush does not start at rank zero");

   // within a flush: ascending distance, consecutive ranks
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && in_frame_ff |->
         !rsp_tuser && rsp_dist >= prev_dist_ff && rsp_rank == next_rank_ff)
      else $error("flush beats out of order");

   // stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

endmodule

bind record_sort_by_distance rsd_check u_rsd_check (.*);

`default_nettype wire

>>> sim/record_sort_by_distance_tb.sv
`default_nettype none

module record_sort_by_distance_tb;
   import rsd_pkg::*;

   localparam int DEPTH       = 32;
   localparam int IDLE_PCT    = 17;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 16;
   localparam int SHOWN_FAULTS = 10;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // one expected result beat of a flush
   typedef struct packed {
      record_type         rec;
      logic [RANK_W-1:0]  rank;
      logic               last_flag;
      logic               empty_flag;
   } flush_beat_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;

   // predictor state: stored records in sorted order, beats still to come
   record_type     sorted_table[$];
   flush_beat_type pending_beats[$];

   int fault_count = 0;
   int items_sent  = 0;
   int cycle_count = 0;
   int hold_left   = 0;
   bit hold_armed  = 1'b0;
   bit steady      = 1'b0;

   record_sort_by_distance #(.TABLE_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: random stalls, a long hold-off on request, none while steady
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_armed) begin
         hold_armed = 1'b0;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic log_fault(input string msg);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS)
         $display("%0d: %s", cycle_count, msg);
   endtask

   // result checker
   always @(posedge clock) begin
      flush_beat_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_beats.size() == 0) begin
            log_fault($sformatf("unexpected beat tdata=%h tlast=%b tuser=%b",
                                rsp_tdata, rsp_tlast, rsp_tuser));
         end else begin
            want = pending_beats.pop_front();
            if (rsp_tdata[REC_W-1:0] !== want.rec ||
                rsp_tdata[REC_W+RANK_W-1:REC_W] !== want.rank ||
                rsp_tdata[RSP_DATA_W-1:REC_W+RANK_W] !== '0 ||
                rsp_tlast !== want.last_flag || rsp_tuser !== want.empty_flag)
               log_fault($sformatf({"mismatch exp dist=%h spd=%h lbl=%h rank=%0d ",
                                    "last=%b none=%b got tdata=%h last=%b none=%b"},
                                   want.rec.distance_m, want.rec.speed_kmh,
                                   want.rec.label, want.rank, want.last_flag,
                                   want.empty_flag, rsp_tdata, rsp_tlast, rsp_tuser));
         end
      end
   end

   // stable insertion on append, sorted drain on flush
   function automatic void model_request(input func_type func, input record_type rec);
      int pos;
      int n;
      flush_beat_type beat;
      n = sorted_table.size();
      if (func == FUNC_APPEND) begin
         if (n < DEPTH) begin
            pos = n;
            while (pos > 0 && sorted_table[pos-1].distance_m > rec.distance_m)
               pos--;
            sorted_table.insert(pos, rec);
         end
      end else if (n == 0) begin
         beat = '0;
         beat.last_flag  = 1'b1;
         beat.empty_flag = 1'b1;
         pending_beats.push_back(beat);
      end else begin
         for (int i = 0; i < n; i++) begin
            beat.rec        = sorted_table[i];
            beat.rank       = RANK_W'(i);
            beat.last_flag  = (i == n - 1);
            beat.empty_flag = 1'b0;
            pending_beats.push_back(beat);
         end
         sorted_table.delete();
      end
   endfunction

   function automatic record_type mk_rec(input logic [DIST_W-1:0] d,
                                         input logic [SPEED_W-1:0] s,
                                         input logic [LABEL_W-1:0] l);
      record_type r;
      r.distance_m = d;
      r.speed_kmh  = s;
      r.label      = l;
      return r;
   endfunction

   // distances lean on a small pool so that ties are common
   function automatic record_type random_record();
      logic [DIST_W-1:0]  d;
      logic [SPEED_W-1:0] s;
      case ($urandom_range(9))
         0:       d = '0;
         1:       d = DIST_MAX;
         2, 3, 4: d = DIST_W'($urandom_range(7) * 1000);
         default: d = DIST_W'($urandom);
      endcase
      case ($urandom_range(7))
         0:       s = '0;
         1:       s = '1;
         default: s = SPEED_W'($urandom_range(511));
      endcase
      return mk_rec(d, s, LABEL_W'($urandom_range(255)));
   endfunction

   // offer one beat, wait for acceptance, then predict
   task automatic send_item(input func_type func, input record_type rec);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {{(REQ_DATA_W-REC_W){1'b0}}, rec};
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      model_request(func, rec);
      items_sent++;
   endtask

   task automatic test_empty_flush();
      send_item(FUNC_FLUSH, '0);
      // payload of a flush is ignored
      send_item(FUNC_FLUSH, mk_rec('1, '1, '1));
   endtask

   task automatic test_extremes_and_ties();
      send_item(FUNC_APPEND, mk_rec(DIST_MAX, '1, 8'hFF));
      send_item(FUNC_APPEND, mk_rec(25'h155_5555, 9'h155, 8'h55));
      send_item(FUNC_APPEND, mk_rec('0, '0, 8'h00));
      send_item(FUNC_APPEND, mk_rec(25'h0AA_AAAA, 9'h0AA, 8'hAA));
      send_item(FUNC_APPEND, mk_rec(25'h155_5555, 9'h001, 8'h01));
      send_item(FUNC_APPEND, mk_rec(DIST_MAX, 9'h100, 8'h02));
      send_item(FUNC_APPEND, mk_rec('0, 9'h1FE, 8'h03));
      send_item(FUNC_APPEND, mk_rec(25'h155_5555, 9'h002, 8'h04));
      send_item(FUNC_FLUSH, '0);
      // single record, then a flush straight after a drain
      send_item(FUNC_APPEND, mk_rec(25'h000_0001, 9'h0FF, 8'h80));
      send_item(FUNC_FLUSH, mk_rec('1, '0, '1));
      send_item(FUNC_FLUSH, '0);
   endtask

   // more appends than the table holds: extras are dropped
   task automatic test_table_full();
      for (int i = 0; i < DEPTH + 4; i++)
         send_item(FUNC_APPEND, random_record());
      send_item(FUNC_FLUSH, random_record());
      send_item(FUNC_APPEND, random_record());
      send_item(FUNC_APPEND, random_record());
      send_item(FUNC_FLUSH, random_record());
   endtask

   // bursts of appends closed by a flush, mostly short
   task automatic test_random(input int count);
      int target;
      int burst;
      target = items_sent + count;
      while (items_sent < target) begin
         case ($urandom_range(19))
            0:          burst = $urandom_range(DEPTH + 8, DEPTH + 1);
            1:          burst = 0;
            2, 3, 4:    burst = $urandom_range(DEPTH - 1, 10);
            default:    burst = $urandom_range(8, 1);
         endcase
         for (int i = 0; i < burst; i++)
            send_item(FUNC_APPEND, random_record());
         send_item(FUNC_FLUSH, random_record());
      end
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      test_random(80);
      steady = 1'b0;
   endtask

   // receiver holds off while full tables keep coming: input must stall
   task automatic test_output_stall();
      hold_armed = 1'b1;
      for (int b = 0; b < 3; b++) begin
         for (int i = 0; i < DEPTH; i++)
            send_item(FUNC_APPEND, random_record());
         send_item(FUNC_FLUSH, random_record());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_flush();
      test_extremes_and_ties();
      test_table_full();
      test_random(160);
      test_back_to_back();
      test_output_stall();
      test_random(40);
      req_tvalid <= 1'b0;
      while (pending_beats.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
